// File: sv/srj_pkg.sv
// ----------------------------------------------------------------------------
// srj_pkg: shared types and constants of the sequenced ring journal
// Ring depth, field widths, command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package srj_pkg;

	localparam int CAPACITY = 32;
	localparam int SEQ_W    = 64;
	localparam int HANDLE_W = 32;
	localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
	localparam logic [CNT_W:0]    CAP_WIDE  = (CNT_W + 1)'(CAPACITY);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	typedef struct packed {
		logic append;
		logic capture;
		logic reply_short;
		logic begin_emit;
		logic emit;
	} srj_cmd_t;

	typedef struct packed {
		logic empty_range;
		logic range_ok;
		logic final_entry;
	} srj_status_t;

endpackage

// File: sv/srj_ram.sv
// ----------------------------------------------------------------------------
// srj_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srj_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/srj_ctrl.sv
// ----------------------------------------------------------------------------
// srj_ctrl: journal controller
// Accepts items, sequences the range check and the entry emission.
// ----------------------------------------------------------------------------
module srj_ctrl import srj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        kind,
	input  srj_status_t status,
	output srj_cmd_t    cmd,
	output logic        busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = start && !busy;

	always_comb begin
		cmd             = '0;
		cmd.append      = accept && (kind == KIND_APPEND);
		cmd.capture     = accept && (kind == KIND_READ);
		cmd.reply_short = (state_q == ST_CHECK) &&
			(status.empty_range || !status.range_ok);
		cmd.begin_emit  = (state_q == ST_CHECK) &&
			!status.empty_range && status.range_ok;
		cmd.emit        = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_CHECK;
						busy    <= 1'b1;
					end
				end
				ST_CHECK: begin
					if (cmd.begin_emit) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
						busy    <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (status.final_entry) begin
						state_q <= ST_IDLE;
						busy    <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: sv/srj_dp.sv
// ----------------------------------------------------------------------------
// srj_dp: journal datapath
// Ring pointers, sequence counters, handle store, range checks and the
// result registers.
// ----------------------------------------------------------------------------
module srj_dp import srj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  srj_cmd_t            cmd,
	input  logic [HANDLE_W-1:0] request_handle,
	input  logic                handle_present,
	input  logic [SEQ_W-1:0]    after_seq,
	input  logic [SEQ_W-1:0]    through_seq,
	output srj_status_t         status,
	output logic                result_strobe,
	output logic [SEQ_W-1:0]    seq_out,
	output logic [HANDLE_W-1:0] handle_out,
	output logic                has_entry,
	output logic                success,
	output logic                last,
	output logic [SEQ_W-1:0]    latest_seq
);

	logic [CNT_W-1:0]    fill_q;
	logic [SLOT_W-1:0]   oldest_q;
	logic [SEQ_W-1:0]    latest_q;
	logic [SEQ_W-1:0]    base_q;
	logic [SEQ_W-1:0]    after_q;
	logic [SEQ_W-1:0]    through_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [CNT_W-1:0]    remain_q;

	logic                full;
	logic                do_store;
	logic [SLOT_W-1:0]   wr_slot;
	logic [SLOT_W-1:0]   oldest_next;
	logic [SLOT_W-1:0]   idx_next;
	logic [SEQ_W-1:0]    offset_full;
	logic [SEQ_W-1:0]    span_full;
	logic [CNT_W:0]      start_sum;
	logic [SLOT_W-1:0]   start_idx;
	logic [HANDLE_W-1:0] rd_handle;

	assign full        = (fill_q == CAP_CNT);
	assign do_store    = cmd.append && handle_present;
	assign wr_slot     = full ? oldest_q : fill_q[SLOT_W-1:0];
	assign oldest_next = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
	assign idx_next    = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	assign offset_full = after_q - base_q;
	assign span_full   = through_q - after_q;
	assign start_sum   = {1'b0, {(CNT_W - SLOT_W){1'b0}}, oldest_q} +
		{1'b0, offset_full[CNT_W-1:0]};
	assign start_idx   = (start_sum >= CAP_WIDE) ?
		SLOT_W'(start_sum - CAP_WIDE) : start_sum[SLOT_W-1:0];

	assign status.empty_range = (after_q >= through_q);
	assign status.range_ok    = (through_q <= latest_q) && (fill_q != '0) &&
		(after_q >= base_q);
	assign status.final_entry = (remain_q == CNT_W'(1));

	assign latest_seq = latest_q;
	assign handle_out = has_entry ? rd_handle : '0;

	srj_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(CAPACITY)
	) u_handle_ram (
		.clk  (clk),
		.we   (do_store),
		.waddr(wr_slot),
		.wdata(request_handle),
		.re   (cmd.emit),
		.raddr(idx_q),
		.rdata(rd_handle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			oldest_q      <= '0;
			latest_q      <= '0;
			base_q        <= '0;
			result_strobe <= 1'b0;
		end else begin
			if (do_store) begin
				latest_q <= latest_q + 1'b1;
				if (full) begin
					oldest_q <= oldest_next;
					base_q   <= base_q + 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			result_strobe <= cmd.append || cmd.reply_short || cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			after_q   <= after_seq;
			through_q <= through_seq;
		end
		if (cmd.begin_emit) begin
			seq_q    <= after_q + 1'b1;
			idx_q    <= start_idx;
			remain_q <= span_full[CNT_W-1:0];
		end else if (cmd.emit) begin
			seq_q    <= seq_q + 1'b1;
			idx_q    <= idx_next;
			remain_q <= remain_q - 1'b1;
		end

		if (cmd.append) begin
			seq_out   <= handle_present ? latest_q + 1'b1 : latest_q;
			has_entry <= 1'b0;
			success   <= 1'b1;
			last      <= 1'b1;
		end else if (cmd.reply_short) begin
			seq_out   <= '0;
			has_entry <= 1'b0;
			success   <= status.empty_range;
			last      <= 1'b1;
		end else if (cmd.emit) begin
			seq_out   <= seq_q;
			has_entry <= 1'b1;
			success   <= 1'b1;
			last      <= status.final_entry;
		end
	end

endmodule

// File: sv/sequenced_ring_journal.sv
// ----------------------------------------------------------------------------
// sequenced_ring_journal: circular log of request handles with sequences
// Keeps the last CAPACITY appended handles, each tagged with a 64-bit
// sequence number, and replays sequence ranges on request.
//
// An item is taken at a rising edge with start high and busy low. Append
// items (kind 0) never raise busy: one can follow in every cycle while no
// read holds busy, and each gives one result in the cycle after it is
// taken. A range read (kind 1) raises busy, performs the range check and
// then streams one held entry per cycle out of the registered handle RAM
// port, in rising sequence order, with last set on the final one; busy
// stays high until the final entry is registered. An empty or failed read
// returns one result, registered at the end of the range check, and busy
// falls with it. Each result is shown for one cycle, marked by
// result_strobe; the receiver cannot stall, so results are never held
// back. latest_seq always reflects the journal after the item shown.
// Reset empties the journal and zeroes the latest sequence at once; the
// handle RAM needs no clearing since only written slots are ever read.
// ----------------------------------------------------------------------------
module sequenced_ring_journal import srj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [HANDLE_W-1:0] request_handle,
	input  logic                handle_present,
	input  logic [SEQ_W-1:0]    after_seq,
	input  logic [SEQ_W-1:0]    through_seq,
	output logic                result_strobe,
	output logic [SEQ_W-1:0]    seq_out,
	output logic [HANDLE_W-1:0] handle_out,
	output logic                has_entry,
	output logic                success,
	output logic                last,
	output logic [SEQ_W-1:0]    latest_seq
);

	srj_cmd_t    cmd;
	srj_status_t status;

	srj_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	srj_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.request_handle(request_handle),
		.handle_present(handle_present),
		.after_seq     (after_seq),
		.through_seq   (through_seq),
		.status        (status),
		.result_strobe (result_strobe),
		.seq_out       (seq_out),
		.handle_out    (handle_out),
		.has_entry     (has_entry),
		.success       (success),
		.last          (last),
		.latest_seq    (latest_seq)
	);

endmodule
